>>> hw/rtl/sft_pkg.sv
// Shared types and constants for the sprite frame timer.
package sft_pkg;

  localparam int unsigned ELAPSED_W  = 40;
  localparam int unsigned WIDE_W     = 41;
  localparam int unsigned DUR_W      = 32;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned FRAME_W    = 8;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [COUNT_W-1:0] MAX_FRAMES   = 9'd256;
  localparam logic [DUR_W-1:0]   MIN_DURATION = 32'd7;
  localparam logic [DUR_W-1:0]   DUR_RESET    = 32'd65536;

  localparam logic [CNT_W-1:0] MOD_STEPS_M1 = 6'd40;
  localparam logic [CNT_W-1:0] DIV_STEPS_M1 = 6'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_DURATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT    = 2'd1;

  localparam logic [2:0] KIND_STEP   = 3'd0;
  localparam logic [2:0] KIND_PLAY   = 3'd1;
  localparam logic [2:0] KIND_STOP   = 3'd2;
  localparam logic [2:0] KIND_PAUSE  = 3'd3;
  localparam logic [2:0] KIND_RESUME = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOTAL,
    ST_CLAMP,
    ST_MOD,
    ST_DIV,
    ST_FIN
  } sft_state_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic             loop_mode;
    logic [DUR_W-1:0] delta_time;
  } sft_in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_index;
    logic               playing;
    logic               finished;
  } sft_out_t;

  typedef struct packed {
    logic              ge;
    logic [WIDE_W-1:0] diff;
  } sft_cmp_t;

endpackage

>>> hw/rtl/sft_sub_unit.sv
// Shared compare and subtract unit used by the clamp, modulo, divide and finish steps.
module sft_sub_unit (
  input  logic [sft_pkg::WIDE_W-1:0] a,
  input  logic [sft_pkg::WIDE_W-1:0] b,
  output sft_pkg::sft_cmp_t          res
);

  logic [sft_pkg::WIDE_W:0] sub;

  assign sub      = {1'b0, a} - {1'b0, b};
  assign res.ge   = ~sub[sft_pkg::WIDE_W];
  assign res.diff = sub[sft_pkg::WIDE_W-1:0];

endmodule

>>> hw/rtl/sprite_frame_timer.sv
// Sprite frame timer top level: command sequencer around one shared subtractor.
// Play, stop, pause, resume and idle time steps pass through the total and finish states to
// out_valid; one-shot time steps add a clamp and a 9-step frame divide, looping time steps
// a 41-step modulo plus the 9-step frame divide, both on the shared subtractor.
// A new command is taken only once the last is finished; in_ready is high only while idle.
// Synchronous active-low reset: 1.0 s frames, no frames, stopped, loop mode on.
module sprite_frame_timer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sft_pkg::sft_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sft_pkg::sft_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [sft_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sft_pkg::DUR_W-1:0]       cfg_wdata
);

  sft_pkg::sft_state_t state_r, state_nxt;

  logic [sft_pkg::DUR_W-1:0]     dur_r, dur_nxt;
  logic [sft_pkg::COUNT_W-1:0]   count_r, count_nxt;
  logic [sft_pkg::ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [sft_pkg::FRAME_W-1:0]   frame_r, frame_nxt;
  logic                          playing_r, playing_nxt;
  logic                          looping_r, looping_nxt;
  logic                          out_valid_r, out_valid_nxt;
  sft_pkg::sft_out_t             out_r, out_nxt;

  sft_pkg::sft_in_t              cmd_r, cmd_nxt;
  logic [sft_pkg::ELAPSED_W-1:0] total_r, total_nxt;
  logic [sft_pkg::WIDE_W-1:0]    e_r, e_nxt;
  logic [sft_pkg::ELAPSED_W-1:0] rem_r, rem_nxt;
  logic [sft_pkg::WIDE_W-1:0]    dsr_r, dsr_nxt;
  logic [sft_pkg::COUNT_W-1:0]   q_r, q_nxt;
  logic [sft_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;

  logic [sft_pkg::COUNT_W-1:0]   n_eff;
  logic                          have;
  logic [sft_pkg::WIDE_W-1:0]    product;
  logic [sft_pkg::WIDE_W-1:0]    op_a, op_b;
  sft_pkg::sft_cmp_t             cmp;
  logic [sft_pkg::COUNT_W-1:0]   q_step;
  logic [sft_pkg::COUNT_W-1:0]   last_frame;

  assign n_eff      = (count_r > sft_pkg::MAX_FRAMES) ? sft_pkg::MAX_FRAMES : count_r;
  assign have       = (n_eff != '0);
  assign product    = {9'd0, dur_r} * {32'd0, n_eff};
  assign last_frame = n_eff - 9'd1;
  assign q_step     = {q_r[sft_pkg::COUNT_W-2:0], cmp.ge};

  assign in_ready  = (state_r == sft_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    case (state_r)
      sft_pkg::ST_CLAMP: begin
        op_a = e_r;
        op_b = {1'b0, total_r};
      end
      sft_pkg::ST_MOD: begin
        op_a = {rem_r, e_r[sft_pkg::WIDE_W-1]};
        op_b = {1'b0, total_r};
      end
      sft_pkg::ST_DIV: begin
        op_a = {1'b0, rem_r};
        op_b = dsr_r;
      end
      default: begin
        op_a = {1'b0, elapsed_r};
        op_b = {1'b0, total_r};
      end
    endcase
  end

  sft_sub_unit u_sub (
    .a   (op_a),
    .b   (op_b),
    .res (cmp)
  );

  always_comb begin
    state_nxt     = state_r;
    dur_nxt       = dur_r;
    count_nxt     = count_r;
    elapsed_nxt   = elapsed_r;
    frame_nxt     = frame_r;
    playing_nxt   = playing_r;
    looping_nxt   = looping_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    cmd_nxt       = cmd_r;
    total_nxt     = total_r;
    e_nxt         = e_r;
    rem_nxt       = rem_r;
    dsr_nxt       = dsr_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      sft_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data;
          state_nxt = sft_pkg::ST_TOTAL;
        end
      end
      sft_pkg::ST_TOTAL: begin
        total_nxt = product[sft_pkg::ELAPSED_W-1:0];
        e_nxt     = {1'b0, elapsed_r} + {9'd0, cmd_r.delta_time};
        state_nxt = sft_pkg::ST_FIN;
        case (cmd_r.kind)
          sft_pkg::KIND_STEP: begin
            if (playing_r && have) begin
              rem_nxt   = '0;
              cnt_nxt   = sft_pkg::MOD_STEPS_M1;
              state_nxt = looping_r ? sft_pkg::ST_MOD : sft_pkg::ST_CLAMP;
            end
          end
          sft_pkg::KIND_PLAY: begin
            looping_nxt = cmd_r.loop_mode;
            elapsed_nxt = '0;
            frame_nxt   = '0;
            playing_nxt = have;
          end
          sft_pkg::KIND_STOP: begin
            playing_nxt = 1'b0;
            elapsed_nxt = '0;
            frame_nxt   = '0;
          end
          sft_pkg::KIND_PAUSE: begin
            playing_nxt = 1'b0;
          end
          sft_pkg::KIND_RESUME: begin
            if (have) begin
              playing_nxt = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      sft_pkg::ST_CLAMP: begin
        if (cmp.ge) begin
          elapsed_nxt = total_r;
          rem_nxt     = total_r;
          playing_nxt = 1'b0;
        end else begin
          elapsed_nxt = e_r[sft_pkg::ELAPSED_W-1:0];
          rem_nxt     = e_r[sft_pkg::ELAPSED_W-1:0];
        end
        dsr_nxt   = {1'b0, dur_r, 8'd0};
        q_nxt     = '0;
        cnt_nxt   = sft_pkg::DIV_STEPS_M1;
        state_nxt = sft_pkg::ST_DIV;
      end
      sft_pkg::ST_MOD: begin
        rem_nxt = cmp.ge ? cmp.diff[sft_pkg::ELAPSED_W-1:0]
                         : op_a[sft_pkg::ELAPSED_W-1:0];
        e_nxt   = {e_r[sft_pkg::WIDE_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          elapsed_nxt = rem_nxt;
          dsr_nxt     = {1'b0, dur_r, 8'd0};
          q_nxt       = '0;
          cnt_nxt     = sft_pkg::DIV_STEPS_M1;
          state_nxt   = sft_pkg::ST_DIV;
        end
      end
      sft_pkg::ST_DIV: begin
        if (cmp.ge) begin
          rem_nxt = cmp.diff[sft_pkg::ELAPSED_W-1:0];
        end
        q_nxt   = q_step;
        dsr_nxt = {1'b0, dsr_r[sft_pkg::WIDE_W-1:1]};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          frame_nxt = (q_step > last_frame) ? last_frame[sft_pkg::FRAME_W-1:0]
                                            : q_step[sft_pkg::FRAME_W-1:0];
          state_nxt = sft_pkg::ST_FIN;
        end
      end
      sft_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.frame_index = frame_r;
          out_nxt.playing     = playing_r;
          out_nxt.finished    = !playing_r && have && cmp.ge;
          out_valid_nxt       = 1'b1;
          state_nxt           = sft_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sft_pkg::ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_index)
        sft_pkg::CFG_FRAME_DURATION: begin
          dur_nxt     = (cfg_wdata < sft_pkg::MIN_DURATION) ? sft_pkg::MIN_DURATION
                                                           : cfg_wdata;
          elapsed_nxt = '0;
          frame_nxt   = '0;
          playing_nxt = 1'b0;
          looping_nxt = 1'b1;
        end
        sft_pkg::CFG_FRAME_COUNT: begin
          count_nxt   = cfg_wdata[sft_pkg::COUNT_W-1:0];
          elapsed_nxt = '0;
          frame_nxt   = '0;
          playing_nxt = 1'b0;
          looping_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sft_pkg::ST_IDLE;
      dur_r       <= sft_pkg::DUR_RESET;
      count_r     <= '0;
      elapsed_r   <= '0;
      frame_r     <= '0;
      playing_r   <= 1'b0;
      looping_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dur_r       <= dur_nxt;
      count_r     <= count_nxt;
      elapsed_r   <= elapsed_nxt;
      frame_r     <= frame_nxt;
      playing_r   <= playing_nxt;
      looping_r   <= looping_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r   <= out_nxt;
    cmd_r   <= cmd_nxt;
    total_r <= total_nxt;
    e_r     <= e_nxt;
    rem_r   <= rem_nxt;
    dsr_r   <= dsr_nxt;
    q_r     <= q_nxt;
    cnt_r   <= cnt_nxt;
  end

endmodule
